[rtl/oidc_pkg.sv]
`timescale 1ns / 1ps

package oidc_pkg;

   // Command codes carried in req_tuser
   localparam logic [1:0] CMD_MECH_TYPE = 2'd0;
   localparam logic [1:0] CMD_THIS_MECH = 2'd1;
   localparam logic [1:0] CMD_CLEAR     = 2'd2;
   localparam logic [1:0] CMD_UNUSED    = 2'd3;

   // Result status codes
   localparam logic [1:0] STATUS_ACCEPTED     = 2'd0;
   localparam logic [1:0] STATUS_NOT_ACCEPTED = 2'd1;
   localparam logic [1:0] STATUS_MALFORMED    = 2'd2;

   // Mechanism codes, target index plus one
   localparam logic [2:0] MECH_NONE  = 3'd0;
   localparam logic [2:0] MECH_NEGO  = 3'd1;
   localparam logic [2:0] MECH_NTLM  = 3'd2;
   localparam logic [2:0] MECH_MSKRB = 3'd3;
   localparam logic [2:0] MECH_KRB   = 3'd4;
   localparam logic [2:0] MECH_U2U   = 3'd5;

   // Target table indexes
   localparam logic [2:0] TGT_NEGO  = 3'd0;
   localparam logic [2:0] TGT_NTLM  = 3'd1;
   localparam logic [2:0] TGT_MSKRB = 3'd2;
   localparam logic [2:0] TGT_KRB   = 3'd3;
   localparam logic [2:0] TGT_U2U   = 3'd4;

   localparam int NUM_TARGETS = 5;
   localparam int TGT_W       = 17;
   localparam logic [3:0] COUNT_MAX = 4'd15;
   localparam logic [4:0] MATCH_ALL = 5'h1F;

   // One input item
   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] data_byte;
      logic       last_byte;
   } req_item_type;

   // Input register contents
   typedef struct packed {
      logic         valid;
      req_item_type item;
   } req_stage_type;

   // One result item
   typedef struct packed {
      logic [1:0] status;
      logic [2:0] mechanism;
      logic [3:0] mech_set;
      logic [2:0] preferred;
   } rsp_item_type;

   // Result handed to the output register
   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } rsp_result_type;

   // Number of sub-identifiers in each target; the first covers two arcs
   function automatic logic [3:0] target_len(input logic [2:0] t);
      logic [3:0] n;
      n = 4'd0;
      unique case (t)
         TGT_NEGO:  n = 4'd6;
         TGT_NTLM:  n = 4'd9;
         TGT_MSKRB: n = 4'd6;
         TGT_KRB:   n = 4'd6;
         TGT_U2U:   n = 4'd7;
         default:   n = 4'd0;
      endcase
      return n;
   endfunction

   // Sub-identifier p of target t; zero beyond its length
   function automatic logic [TGT_W-1:0] target_subid(input logic [2:0] t,
                                                    input logic [3:0] p);
      logic [TGT_W-1:0] v;
      v = '0;
      unique case (t)
         TGT_NEGO: begin
            unique case (p)
               4'd0:    v = 17'd43;
               4'd1:    v = 17'd6;
               4'd2:    v = 17'd1;
               4'd3:    v = 17'd5;
               4'd4:    v = 17'd5;
               4'd5:    v = 17'd2;
               default: v = '0;
            endcase
         end
         TGT_NTLM: begin
            unique case (p)
               4'd0:    v = 17'd43;
               4'd1:    v = 17'd6;
               4'd2:    v = 17'd1;
               4'd3:    v = 17'd4;
               4'd4:    v = 17'd1;
               4'd5:    v = 17'd311;
               4'd6:    v = 17'd2;
               4'd7:    v = 17'd2;
               4'd8:    v = 17'd10;
               default: v = '0;
            endcase
         end
         TGT_MSKRB: begin
            unique case (p)
               4'd0:    v = 17'd42;
               4'd1:    v = 17'd840;
               4'd2:    v = 17'd48018;
               4'd3:    v = 17'd1;
               4'd4:    v = 17'd2;
               4'd5:    v = 17'd2;
               default: v = '0;
            endcase
         end
         TGT_KRB, TGT_U2U: begin
            unique case (p)
               4'd0:    v = 17'd42;
               4'd1:    v = 17'd840;
               4'd2:    v = 17'd113554;
               4'd3:    v = 17'd1;
               4'd4:    v = 17'd2;
               4'd5:    v = 17'd2;
               4'd6:    v = (t == TGT_U2U) ? 17'd3 : 17'd0;
               default: v = '0;
            endcase
         end
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

[rtl/oid_decode_and_classify_core.sv]
`timescale 1ns / 1ps

// Decodes the content bytes of a BER object identifier, one byte per item,
// and classifies it against the negotiation, NTLM, MS Kerberos, Kerberos and
// Kerberos user-to-user mechanism identifiers. One item is taken every cycle
// while req_tready is high. An item is held in an input register and decoded
// from there, and its result is held in an output register that drives rsp.
// Only the last byte of an identifier under cmd 0 or 1 gives a result; cmd 2
// clears the kept mechanism set and any identifier in progress, cmd 3 is
// ignored. A stalled result does not hold up bytes that give no result; the
// next last byte waits in the input register, and then req_tready drops.
module oid_decode_and_classify_core #(
   parameter int SUBID_BITS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [1:0]  req_tuser,   // [1:0] cmd
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [1:0] status, [4:2] mechanism,
                                    // [8:5] mech_set, [11:9] preferred
);

   oidc_pkg::req_item_type   req_item;
   oidc_pkg::req_stage_type  stage;
   oidc_pkg::rsp_result_type result;
   oidc_pkg::rsp_item_type   rsp_item;
   logic                     out_free;
   logic                     gives_result;
   logic                     step;

   assign req_item.cmd       = req_tuser;
   assign req_item.data_byte = req_tdata;
   assign req_item.last_byte = req_tlast;

   // A byte that yields a result waits for room in the output register
   assign gives_result = stage.item.last_byte &&
                         (stage.item.cmd == oidc_pkg::CMD_MECH_TYPE ||
                          stage.item.cmd == oidc_pkg::CMD_THIS_MECH);
   assign step = stage.valid && (!gives_result || out_free);

   oidc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .consume    (step),
      .stage      (stage)
   );

   oidc_decode #(
      .SUBID_BITS (SUBID_BITS)
   ) u_decode (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (stage.item),
      .result (result)
   );

   oidc_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .result     (result),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item)
   );

   assign rsp_tdata = {4'd0, rsp_item.preferred, rsp_item.mech_set,
                       rsp_item.mechanism, rsp_item.status};

endmodule

[rtl/oidc_in_stage.sv]
`timescale 1ns / 1ps

module oidc_in_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  oidc_pkg::req_item_type req_item,
   input  logic                   consume,
   output oidc_pkg::req_stage_type stage
);

   logic                   valid_ff, valid_in;
   oidc_pkg::req_item_type item_ff;

   // Slot is free when empty or being drained this cycle
   assign req_tready = !valid_ff || consume;

   always_comb begin
      valid_in = valid_ff;
      if (req_tvalid && req_tready) begin
         valid_in = 1'b1;
      end else if (consume) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload, no reset
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= req_item;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;

endmodule

[rtl/oidc_decode.sv]
`timescale 1ns / 1ps

module oidc_decode #(
   parameter int SUBID_BITS = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  oidc_pkg::req_item_type  item,
   output oidc_pkg::rsp_result_type result
);

   logic [SUBID_BITS-1:0] accum_ff, accum_in;
   logic                  in_subid_ff, in_subid_in;
   logic                  broken_ff, broken_in;
   logic [3:0]            count_ff, count_in;
   logic [4:0]            match_ff, match_in;
   logic                  mode_ff, mode_in;
   logic                  in_ident_ff, in_ident_in;
   logic [3:0]            record_ff, record_in;
   logic [2:0]            pref_ff, pref_in;

   logic [SUBID_BITS-1:0] subid;
   logic                  overflow;
   logic [2:0]            mech;
   logic                  found;
   logic [1:0]            status;
   logic                  is_byte;

   assign is_byte  = (item.cmd == oidc_pkg::CMD_MECH_TYPE) ||
                     (item.cmd == oidc_pkg::CMD_THIS_MECH);
   assign overflow = (accum_ff[SUBID_BITS-1 -: 7] != 7'd0);
   assign subid    = {accum_ff[SUBID_BITS-8:0], item.data_byte[6:0]};

   // Per-byte decode, match and classify
   always_comb begin
      accum_in    = accum_ff;
      in_subid_in = in_subid_ff;
      broken_in   = broken_ff;
      count_in    = count_ff;
      match_in    = match_ff;
      mode_in     = mode_ff;
      in_ident_in = in_ident_ff;
      record_in   = record_ff;
      pref_in     = pref_ff;
      mech        = oidc_pkg::MECH_NONE;
      found       = 1'b0;
      status      = oidc_pkg::STATUS_NOT_ACCEPTED;

      if (step && item.cmd == oidc_pkg::CMD_CLEAR) begin
         accum_in    = '0;
         in_subid_in = 1'b0;
         broken_in   = 1'b0;
         count_in    = 4'd0;
         match_in    = oidc_pkg::MATCH_ALL;
         mode_in     = 1'b0;
         in_ident_in = 1'b0;
         record_in   = 4'd0;
         pref_in     = 3'd0;
      end else if (step && is_byte) begin
         // mode is latched at the first byte of an identifier
         if (!in_ident_ff) begin
            mode_in = (item.cmd == oidc_pkg::CMD_THIS_MECH);
         end
         in_ident_in = 1'b1;

         // base-128 accumulate, overflow check before the shift
         if (!broken_ff) begin
            if (overflow) begin
               broken_in = 1'b1;
            end else begin
               accum_in    = subid;
               in_subid_in = 1'b1;
               if (!item.data_byte[7]) begin
                  for (int t = 0; t < oidc_pkg::NUM_TARGETS; t++) begin
                     if (count_ff >= oidc_pkg::target_len(3'(t)) ||
                         subid != SUBID_BITS'(oidc_pkg::target_subid(3'(t), count_ff))) begin
                        match_in[t] = 1'b0;
                     end
                  end
                  if (count_ff < oidc_pkg::COUNT_MAX) begin
                     count_in = count_ff + 4'd1;
                  end
                  accum_in    = '0;
                  in_subid_in = 1'b0;
               end
            end
         end

         // classify on the last byte
         if (item.last_byte) begin
            for (int t = 0; t < oidc_pkg::NUM_TARGETS; t++) begin
               if (!found && match_in[t] && count_in == oidc_pkg::target_len(3'(t))) begin
                  found = 1'b1;
                  mech  = 3'(t + 1);
               end
            end
            if (broken_in || in_subid_in) begin
               status = oidc_pkg::STATUS_MALFORMED;
               mech   = oidc_pkg::MECH_NONE;
            end else if (mode_in) begin
               status = (mech == oidc_pkg::MECH_NEGO) ? oidc_pkg::STATUS_ACCEPTED :
                                                        oidc_pkg::STATUS_NOT_ACCEPTED;
            end else if (mech >= oidc_pkg::MECH_NTLM) begin
               status    = oidc_pkg::STATUS_ACCEPTED;
               record_in = record_ff | (4'd1 << 2'(mech - oidc_pkg::MECH_NTLM));
               if (pref_ff == 3'd0) begin
                  pref_in = mech - 3'd1;
               end
            end else begin
               status = oidc_pkg::STATUS_NOT_ACCEPTED;
            end

            // identifier done
            accum_in    = '0;
            in_subid_in = 1'b0;
            broken_in   = 1'b0;
            count_in    = 4'd0;
            match_in    = oidc_pkg::MATCH_ALL;
            in_ident_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff    <= '0;
         in_subid_ff <= 1'b0;
         broken_ff   <= 1'b0;
         count_ff    <= 4'd0;
         match_ff    <= oidc_pkg::MATCH_ALL;
         mode_ff     <= 1'b0;
         in_ident_ff <= 1'b0;
         record_ff   <= 4'd0;
         pref_ff     <= 3'd0;
      end else begin
         accum_ff    <= accum_in;
         in_subid_ff <= in_subid_in;
         broken_ff   <= broken_in;
         count_ff    <= count_in;
         match_ff    <= match_in;
         mode_ff     <= mode_in;
         in_ident_ff <= in_ident_in;
         record_ff   <= record_in;
         pref_ff     <= pref_in;
      end
   end

   // Result item for the output register
   assign result.valid          = step && is_byte && item.last_byte;
   assign result.item.status    = status;
   assign result.item.mechanism = mech;
   assign result.item.mech_set  = record_in;
   assign result.item.preferred = pref_in;

   // Between identifiers the decoder sits at its idle values
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      !in_ident_ff |-> (count_ff == 4'd0 && !in_subid_ff && !broken_ff &&
                        match_ff == oidc_pkg::MATCH_ALL && accum_ff == '0))
      else $error("decoder state not clean between identifiers");

   // Preferred mechanism is always part of the kept set
   a_pref_in_set: assert property (@(posedge clock) disable iff (reset)
      pref_ff != 3'd0 |-> (pref_ff <= 3'd4 && record_ff[2'(pref_ff - 3'd1)]))
      else $error("preferred mechanism missing from kept set");

   // A malformed identifier names no mechanism and leaves the record alone
   a_malformed: assert property (@(posedge clock) disable iff (reset)
      (result.valid && result.item.status == oidc_pkg::STATUS_MALFORMED) |=>
         (record_ff == $past(record_ff) && pref_ff == $past(pref_ff) &&
          $past(result.item.mechanism) == oidc_pkg::MECH_NONE))
      else $error("malformed identifier changed the record");

endmodule

[rtl/oidc_out_stage.sv]
`timescale 1ns / 1ps

module oidc_out_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  oidc_pkg::rsp_result_type result,
   output logic                     free,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output oidc_pkg::rsp_item_type   rsp_item
);

   logic                   valid_ff, valid_in;
   oidc_pkg::rsp_item_type item_ff;

   // Can take a result when empty or being read this cycle
   assign free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (result.valid) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         item_ff <= result.item;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_item   = item_ff;

endmodule
